@@ hw/rtl/class_decision_debouncer_macros.svh @@
// Assertion macros for the class decision debouncer checker.
// Each macro samples on the rising edge of a signal named clk in the user's scope.
`ifndef CLASS_DECISION_DEBOUNCER_MACROS_SVH
`define CLASS_DECISION_DEBOUNCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cdd_pkg.sv @@
// Shared types, widths, class and register codes for the class decision debouncer.
// No dependencies; every other file but the macro header refers to this package.
package cdd_pkg;

  localparam int unsigned PROB_W     = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned GATE_W     = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned HITS_W     = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned NUM_CLS    = 4;

  // Queue depth between front and back; must be a power of two.
  localparam int unsigned QDEPTH     = 2;

  localparam int unsigned HITS_FOR_OTHER_DEF = 3;
  localparam int unsigned HITS_FOR_EVENT_DEF = 2;

  typedef logic [1:0]        cls_t;
  typedef logic [PROB_W-1:0] prob_t;
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam cls_t CLS_COUGH  = 2'd0;
  localparam cls_t CLS_OTHER  = 2'd1;
  localparam cls_t CLS_SNEEZE = 2'd2;
  localparam cls_t CLS_SPEECH = 2'd3;

  localparam reg_idx_t REG_MIN_COUGH     = 4'd0;
  localparam reg_idx_t REG_MIN_OTHER     = 4'd1;
  localparam reg_idx_t REG_MIN_SNEEZE    = 4'd2;
  localparam reg_idx_t REG_MIN_SPEECH    = 4'd3;
  localparam reg_idx_t REG_STRONG_COUGH  = 4'd4;
  localparam reg_idx_t REG_STRONG_SNEEZE = 4'd5;
  localparam reg_idx_t REG_STRONG_SPEECH = 4'd6;
  localparam reg_idx_t REG_AUDIO_GATE    = 4'd7;

  localparam prob_t MIN_EVENT_RST = 16'd32768;
  localparam prob_t MIN_OTHER_RST = 16'd0;
  localparam prob_t STRONG_RST    = 16'd58982;
  localparam logic [GATE_W-1:0] GATE_RST = 32'd0;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // One classified window as it travels from the front to the back.
  typedef struct packed {
    prob_t [NUM_CLS-1:0] prob;
    cls_t                top;
    logic                active;
    cls_t                prop;
    logic                firm;
  } cdd_item_t;

  typedef struct packed {
    cls_t              steady_cls;
    logic              cls_moved;
    logic [PCT_W-1:0]  conf_pct;
    logic [SEQ_W-1:0]  sequence_res;
    logic              cough_onset;
    cls_t              raw_top;
    logic              audio_active;
  } cdd_result_t;

endpackage

@@ hw/rtl/cdd_in_if.sv @@
// Input window channel: valid/ready handshake with the four class probabilities
// and the audio levels. Depends on cdd_pkg.
interface cdd_in_if;
  logic                         valid;
  logic                         ready;
  cdd_pkg::prob_t               prob_cough;
  cdd_pkg::prob_t               prob_other;
  cdd_pkg::prob_t               prob_sneeze;
  cdd_pkg::prob_t               prob_speech;
  logic [cdd_pkg::LEVEL_W-1:0]  audio_peak;
  logic [cdd_pkg::LEVEL_W-1:0]  audio_mean_abs;

  modport source (output valid, prob_cough, prob_other, prob_sneeze, prob_speech,
                  audio_peak, audio_mean_abs, input ready);
  modport sink   (input valid, prob_cough, prob_other, prob_sneeze, prob_speech,
                  audio_peak, audio_mean_abs, output ready);
endinterface

@@ hw/rtl/cdd_out_if.sv @@
// Result channel: valid/ready handshake with the debounced decision fields.
// Depends on cdd_pkg.
interface cdd_out_if;
  logic                        valid;
  logic                        ready;
  cdd_pkg::cls_t               steady_cls;
  logic                        cls_moved;
  logic [cdd_pkg::PCT_W-1:0]   conf_pct;
  logic [cdd_pkg::SEQ_W-1:0]   sequence_res;
  logic                        cough_onset;
  cdd_pkg::cls_t               raw_top;
  logic                        audio_active;

  modport source (output valid, steady_cls, cls_moved, conf_pct,
                  sequence_res, cough_onset, raw_top, audio_active, input ready);
  modport sink   (input valid, steady_cls, cls_moved, conf_pct,
                  sequence_res, cough_onset, raw_top, audio_active, output ready);
endinterface

@@ hw/rtl/cdd_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on cdd_pkg.
interface cdd_cfg_if;
  logic                            valid;
  logic                            ready;
  cdd_pkg::reg_idx_t               index;
  logic [cdd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/cdd_front.sv @@
// Front end: holds the configuration registers, accepts windows and classifies them
// (top class, audio gate, proposal, strong flag). Depends on cdd_pkg and the interfaces.
module cdd_front (
  input  logic               clk,
  input  logic               rst_n,
  cdd_in_if.sink             in_bus,
  cdd_cfg_if.sink            cfg_bus,
  input  logic               q_ready,
  output logic               q_push,
  output cdd_pkg::cdd_item_t q_item
);

  cdd_pkg::prob_t min_cough_r, min_other_r, min_sneeze_r, min_speech_r;
  cdd_pkg::prob_t strong_cough_r, strong_sneeze_r, strong_speech_r;
  logic [cdd_pkg::GATE_W-1:0] gate_r;

  cdd_pkg::prob_t [cdd_pkg::NUM_CLS-1:0] prob;
  cdd_pkg::cls_t  top;
  cdd_pkg::cls_t  prop;
  cdd_pkg::prob_t min_sel;
  cdd_pkg::prob_t pprob;
  logic           active;
  logic           firm;

  // Register writes are always taken; unknown indexes fall through harmlessly.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cough_r     <= cdd_pkg::MIN_EVENT_RST;
      min_other_r     <= cdd_pkg::MIN_OTHER_RST;
      min_sneeze_r    <= cdd_pkg::MIN_EVENT_RST;
      min_speech_r    <= cdd_pkg::MIN_EVENT_RST;
      strong_cough_r  <= cdd_pkg::STRONG_RST;
      strong_sneeze_r <= cdd_pkg::STRONG_RST;
      strong_speech_r <= cdd_pkg::STRONG_RST;
      gate_r          <= cdd_pkg::GATE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        cdd_pkg::REG_MIN_COUGH:     min_cough_r     <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_MIN_OTHER:     min_other_r     <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_MIN_SNEEZE:    min_sneeze_r    <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_MIN_SPEECH:    min_speech_r    <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_STRONG_COUGH:  strong_cough_r  <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_STRONG_SNEEZE: strong_sneeze_r <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_STRONG_SPEECH: strong_speech_r <= cfg_bus.data[cdd_pkg::PROB_W-1:0];
        cdd_pkg::REG_AUDIO_GATE:    gate_r          <= cfg_bus.data[cdd_pkg::GATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prob[cdd_pkg::CLS_COUGH]  = in_bus.prob_cough;
    prob[cdd_pkg::CLS_OTHER]  = in_bus.prob_other;
    prob[cdd_pkg::CLS_SNEEZE] = in_bus.prob_sneeze;
    prob[cdd_pkg::CLS_SPEECH] = in_bus.prob_speech;

    // Strictly greater, so a tie keeps the lower class index.
    top = cdd_pkg::CLS_COUGH;
    for (int i = 1; i < cdd_pkg::NUM_CLS; i++) begin
      if (prob[i] > prob[top]) begin
        top = cdd_pkg::cls_t'(i);
      end
    end

    active = (in_bus.audio_peak >= gate_r[cdd_pkg::LEVEL_W-1:0]) ||
             (in_bus.audio_mean_abs >= gate_r[cdd_pkg::GATE_W-1:cdd_pkg::LEVEL_W]);

    case (top)
      cdd_pkg::CLS_COUGH:  min_sel = min_cough_r;
      cdd_pkg::CLS_OTHER:  min_sel = min_other_r;
      cdd_pkg::CLS_SNEEZE: min_sel = min_sneeze_r;
      default:             min_sel = min_speech_r;
    endcase

    prop  = top;
    pprob = prob[top];
    if (!active || (prob[top] < min_sel)) begin
      prop  = cdd_pkg::CLS_OTHER;
      pprob = prob[cdd_pkg::CLS_OTHER];
    end

    // An other proposal is never strong.
    case (prop)
      cdd_pkg::CLS_COUGH:  firm = pprob >= strong_cough_r;
      cdd_pkg::CLS_SNEEZE: firm = pprob >= strong_sneeze_r;
      cdd_pkg::CLS_SPEECH: firm = pprob >= strong_speech_r;
      default:             firm = 1'b0;
    endcase

    q_item.prob   = prob;
    q_item.top    = top;
    q_item.active = active;
    q_item.prop   = prop;
    q_item.firm   = firm;
  end

  assign in_bus.ready = q_ready;
  assign q_push       = in_bus.valid && q_ready;

endmodule

@@ hw/rtl/cdd_queue.sv @@
// Short queue of classified windows between the front and the back end.
// Depends on cdd_pkg.
module cdd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cdd_pkg::cdd_item_t push_item,
  output logic               push_ready,
  output logic               head_valid,
  output cdd_pkg::cdd_item_t head_item,
  input  logic               pop
);

  localparam int unsigned PTR_W = (cdd_pkg::QDEPTH > 1) ? $clog2(cdd_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(cdd_pkg::QDEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cdd_pkg::QDEPTH);

  cdd_pkg::cdd_item_t mem_r [cdd_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign push_ready = cnt_r != CNT_FULL;
  assign head_valid = cnt_r != '0;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/cdd_back.sv @@
// Back end: hit counting, confirmation and the stable class, percent and sequence
// number, with the registered result beat. Depends on cdd_pkg and cdd_out_if.
module cdd_back #(
  parameter int unsigned HITS_FOR_OTHER = cdd_pkg::HITS_FOR_OTHER_DEF,
  parameter int unsigned HITS_FOR_EVENT = cdd_pkg::HITS_FOR_EVENT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  cdd_pkg::cdd_item_t head_item,
  output logic               pop,
  cdd_out_if.source          out_bus
);

  localparam logic [cdd_pkg::HITS_W-1:0] NEED_OTHER = cdd_pkg::HITS_W'(HITS_FOR_OTHER);
  localparam logic [cdd_pkg::HITS_W-1:0] NEED_EVENT = cdd_pkg::HITS_W'(HITS_FOR_EVENT);

  cdd_pkg::cls_t                pend_class_r;
  logic [cdd_pkg::HITS_W-1:0]   pend_hits_r, pend_hits_nxt;
  cdd_pkg::cls_t                conf_class_r, conf_class_nxt;
  logic                         conf_valid_r;
  logic [cdd_pkg::SEQ_W-1:0]    count_r, count_nxt;
  logic                         out_valid_r;
  cdd_pkg::cdd_result_t         result_r, result_nxt;

  logic [cdd_pkg::HITS_W-1:0]   need;
  logic                         confirmed;
  logic                         changed;
  cdd_pkg::prob_t               sel_prob;
  logic [23:0]                  scaled;
  logic [23:0]                  quot_sum;
  logic [7:0]                   quot;
  logic [cdd_pkg::PCT_W-1:0]    percent;

  assign pop = head_valid && (!out_valid_r || out_bus.ready);

  always_comb begin
    if (head_item.prop == pend_class_r) begin
      pend_hits_nxt = (pend_hits_r == '1) ? pend_hits_r
                                          : cdd_pkg::HITS_W'(pend_hits_r + 1'b1);
    end else begin
      pend_hits_nxt = cdd_pkg::HITS_W'(1);
    end

    need      = (head_item.prop == cdd_pkg::CLS_OTHER) ? NEED_OTHER : NEED_EVENT;
    confirmed = head_item.firm || (pend_hits_nxt >= need);
    changed   = confirmed && (!conf_valid_r || (head_item.prop != conf_class_r));

    // Until the first confirmation the class register still holds other.
    conf_class_nxt = changed ? head_item.prop : conf_class_r;
    count_nxt      = cdd_pkg::SEQ_W'(count_r + 1'b1);

    // Percent is floor((200p + 65535) / 131070). Halving first leaves a division
    // by 65535, done as (y + (y >> 16) + 1) >> 16, exact for these magnitudes.
    sel_prob = head_item.prob[conf_class_nxt];
    scaled   = {1'b0, sel_prob, 7'd0} + {2'd0, sel_prob, 6'd0} + {5'd0, sel_prob, 3'd0}
               + 24'd65535;
    quot_sum = {1'b0, scaled[23:1]} + {17'd0, scaled[23:17]} + 24'd1;
    quot     = quot_sum[23:16];
    percent  = (quot > {1'b0, cdd_pkg::PCT_MAX}) ? cdd_pkg::PCT_MAX
                                                 : quot[cdd_pkg::PCT_W-1:0];

    result_nxt.steady_cls   = conf_class_nxt;
    result_nxt.cls_moved    = changed;
    result_nxt.conf_pct     = percent;
    result_nxt.sequence_res = count_nxt;
    result_nxt.cough_onset  = changed && (head_item.prop == cdd_pkg::CLS_COUGH);
    result_nxt.raw_top      = head_item.top;
    result_nxt.audio_active = head_item.active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_class_r <= cdd_pkg::CLS_OTHER;
      pend_hits_r  <= '0;
      conf_class_r <= cdd_pkg::CLS_OTHER;
      conf_valid_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else if (pop) begin
      pend_class_r <= head_item.prop;
      pend_hits_r  <= pend_hits_nxt;
      conf_class_r <= conf_class_nxt;
      conf_valid_r <= conf_valid_r | changed;
      count_r      <= count_nxt;
      out_valid_r  <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.steady_cls   = result_r.steady_cls;
  assign out_bus.cls_moved    = result_r.cls_moved;
  assign out_bus.conf_pct     = result_r.conf_pct;
  assign out_bus.sequence_res = result_r.sequence_res;
  assign out_bus.cough_onset  = result_r.cough_onset;
  assign out_bus.raw_top      = result_r.raw_top;
  assign out_bus.audio_active = result_r.audio_active;

endmodule

@@ hw/rtl/class_decision_debouncer.sv @@
// Class decision debouncer top level; depends on cdd_pkg, the channel interfaces and
// cdd_front, cdd_queue, cdd_back. Once a window is accepted, its result beat passes
// through the queue and then the output register, and holds until taken. One window
// is accepted every cycle while the queue has room; the two-entry queue and the output
// register let input and output stall independently. Reset (synchronous, active low)
// restores the register defaults and clears queue, hit count, class and sequence at once.
module class_decision_debouncer #(
  parameter int unsigned HITS_FOR_OTHER = cdd_pkg::HITS_FOR_OTHER_DEF,
  parameter int unsigned HITS_FOR_EVENT = cdd_pkg::HITS_FOR_EVENT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cdd_in_if.sink    in_bus,
  cdd_out_if.source out_bus,
  cdd_cfg_if.sink   cfg_bus
);

  logic               q_push;
  logic               q_ready;
  cdd_pkg::cdd_item_t q_item;
  logic               head_valid;
  cdd_pkg::cdd_item_t head_item;
  logic               pop;

  cdd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  cdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .push_ready (q_ready),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  cdd_back #(
    .HITS_FOR_OTHER (HITS_FOR_OTHER),
    .HITS_FOR_EVENT (HITS_FOR_EVENT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

@@ hw/rtl/cdd_checker.sv @@
// Port-level checks on the result channel of the debouncer, bound to the top level.
// Depends on cdd_pkg and class_decision_debouncer_macros.svh.
`include "class_decision_debouncer_macros.svh"

module cdd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input cdd_pkg::cls_t              out_steady_cls,
  input logic                       out_cls_moved,
  input logic [cdd_pkg::PCT_W-1:0]  out_conf_pct,
  input logic [cdd_pkg::SEQ_W-1:0]  out_sequence_res,
  input logic                       out_cough_onset
);

  logic                      seen_r;
  logic [cdd_pkg::SEQ_W-1:0] seq_last_r;
  cdd_pkg::cls_t             cls_last_r;

  // Remember the last beat taken so that the next one can be compared with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      seq_last_r <= out_sequence_res;
      cls_last_r <= out_steady_cls;
    end
  end

  `CDD_ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid straight after reset")
  `CDD_ASSERT_NOW(a_onset_is_cough, rst_n && out_valid && out_cough_onset, out_cls_moved && (out_steady_cls == cdd_pkg::CLS_COUGH), "cough onset without change to cough")
  `CDD_ASSERT_NOW(a_percent_range, rst_n && out_valid, out_conf_pct <= cdd_pkg::PCT_MAX, "confidence above one hundred")
  `CDD_ASSERT_NOW(a_seq_step, rst_n && out_valid && seen_r, out_sequence_res == cdd_pkg::SEQ_W'(seq_last_r + 1'b1), "sequence number skipped or repeated")
  `CDD_ASSERT_NOW(a_class_hold, rst_n && out_valid && seen_r && !out_cls_moved, out_steady_cls == cls_last_r, "stable class moved without a change flag")

endmodule

bind class_decision_debouncer cdd_checker u_cdd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_steady_cls   (out_bus.steady_cls),
  .out_cls_moved    (out_bus.cls_moved),
  .out_conf_pct     (out_bus.conf_pct),
  .out_sequence_res (out_bus.sequence_res),
  .out_cough_onset  (out_bus.cough_onset)
);
